/* sv/quintic_boundary_polynomial_eval_core_macros.svh */
// Assertion shorthands for the evaluator core.
`ifndef QUINTIC_BOUNDARY_POLYNOMIAL_EVAL_CORE_MACROS_SVH
`define QUINTIC_BOUNDARY_POLYNOMIAL_EVAL_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QBPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QBPE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/qbpe_pkg.sv */
package qbpe_pkg;

    // Value format: signed, VW bits in total, FW of them fractional.
    localparam int VW    = 48;
    localparam int FW    = 24;
    localparam int PW    = 2 * VW;
    localparam int DW    = VW + FW;
    localparam int LW    = VW - 1;
    localparam int KW    = 3;
    localparam int CW    = 3;
    localparam int NCOEF = 6;
    localparam int NSTEP = NCOEF - 1;
    localparam int LAT   = 3 + 3 * NSTEP;
    localparam int CNTW  = $clog2(DW + 1);

    typedef logic signed [VW-1:0] t_val;

    typedef struct packed {
        logic [KW-1:0]        derivative_order;
        logic signed [VW-1:0] eval_point;
    } t_item;

    typedef struct packed {
        logic signed [VW-1:0] value;
        logic signed [VW-1:0] coefficient;
        logic                 saturated;
    } t_result;

    // A value together with its clamp flag.
    typedef struct packed {
        logic signed [VW-1:0] val;
        logic                 clamp;
    } t_sat;

    // Data that rides along one evaluation stage.
    typedef struct packed {
        logic [KW-1:0]        k;
        logic signed [VW-1:0] t;
        logic signed [VW-1:0] acc;
        logic                 flag;
    } t_evs;

    typedef enum logic [CW-1:0] {
        REG_X0  = 3'd0,
        REG_V0  = 3'd1,
        REG_A0  = 3'd2,
        REG_X1  = 3'd3,
        REG_V1  = 3'd4,
        REG_A1  = 3'd5,
        REG_LEN = 3'd6
    } t_cfg_idx;

    localparam t_val VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam t_val VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [LW-1:0] LEN_ONE = LW'(1) << FW;
    localparam logic signed [PW:0] RND = $signed({{(PW+1-FW){1'b0}}, 1'b1, {(FW-1){1'b0}}});

    // Derivative weights j!/(j-k)!, rows by order k, columns by power j.
    localparam logic signed [7:0] WEIGHT [8][6] = '{
        '{8'sd1, 8'sd1, 8'sd1, 8'sd1,  8'sd1,  8'sd1},
        '{8'sd0, 8'sd1, 8'sd2, 8'sd3,  8'sd4,  8'sd5},
        '{8'sd0, 8'sd0, 8'sd2, 8'sd6,  8'sd12, 8'sd20},
        '{8'sd0, 8'sd0, 8'sd0, 8'sd6,  8'sd24, 8'sd60},
        '{8'sd0, 8'sd0, 8'sd0, 8'sd0,  8'sd24, 8'sd120},
        '{8'sd0, 8'sd0, 8'sd0, 8'sd0,  8'sd0,  8'sd120},
        '{8'sd0, 8'sd0, 8'sd0, 8'sd0,  8'sd0,  8'sd0},
        '{8'sd0, 8'sd0, 8'sd0, 8'sd0,  8'sd0,  8'sd0}
    };

    // Clamp a wide signed value into the value range.
    function automatic t_sat sat_wide(input logic signed [PW:0] x);
        t_sat r;
        r.val   = x[VW-1:0];
        r.clamp = 1'b0;
        if (x > $signed({{(PW-VW+1){1'b0}}, VMAX})) begin
            r.val   = VMAX;
            r.clamp = 1'b1;
        end else if (x < $signed({{(PW-VW+1){1'b1}}, VMIN})) begin
            r.val   = VMIN;
            r.clamp = 1'b1;
        end
        return r;
    endfunction

    // Round a full product back to the value format.
    function automatic t_sat mul_round(input logic signed [PW-1:0] p);
        logic signed [PW:0] s;
        s = (PW+1)'(p) + RND;
        s = s >>> FW;
        return sat_wide(s);
    endfunction

    function automatic t_sat add_sat(input t_val a, input t_val b);
        return sat_wide((PW+1)'(a) + (PW+1)'(b));
    endfunction

    function automatic t_sat sub_sat(input t_val a, input t_val b);
        return sat_wide((PW+1)'(a) - (PW+1)'(b));
    endfunction

    // Small integer times a value, exact before the clamp.
    function automatic t_sat scale_sat(input logic signed [7:0] w, input t_val c);
        logic signed [VW+7:0] p;
        p = c * w;
        return sat_wide((PW+1)'(p));
    endfunction

    // Halving with rounding up; it cannot leave the range.
    function automatic t_val half(input t_val a);
        logic signed [VW:0] s;
        s = (VW+1)'(a) + (VW+1)'(1);
        return s[VW:1];
    endfunction

endpackage

/* sv/quintic_boundary_polynomial_eval_core.sv */
// Quintic boundary polynomial evaluator. A start beat is taken at a rising edge where start is
// high and busy is low, so one item per clock can enter while busy is low. Its result is driven
// on o_result with o_valid high for exactly one cycle. Results leave in order. The result
// side has no backpressure, so the receiver must take every beat in the cycle it is shown. The
// evaluation pipeline has an input register, one init stage, three stages per Horner step
// (partial products, rounding, coefficient add) and an output register. A configuration write
// recomputes the six coefficients with one shared two-pass multiplier and one bit-per-cycle
// divider. Busy is high from the write until the derivation ends, and starts are not taken then.
`include "quintic_boundary_polynomial_eval_core_macros.svh"

module quintic_boundary_polynomial_eval_core import qbpe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  t_item         i_item,
    output logic          busy,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_index,
    input  logic [VW-1:0] i_cfg_data,
    output logic          o_valid,
    output t_result       o_result
);

    typedef enum logic [3:0] {
        D_IDLE, D_T2, D_T3, D_N0A, D_N0B, D_K0, D_N1, D_K1, D_K2, D_C3, D_C4, D_C5
    } t_dstate;

    typedef enum logic [1:0] {PH_LOAD, PH_RUN, PH_DONE} t_phase;

    // Configuration registers and derived state.
    t_val            r_x0, r_v0, r_a0, r_x1, r_v1, r_a1;
    logic [LW-1:0]   r_len;
    t_val            r_coef [NCOEF];
    logic            r_dsat, r_dclamp, r_busy;
    t_dstate         r_dstate, d_next;
    t_phase          r_ph;
    t_val            r_t2, r_t3, r_n, r_k0, r_k1, r_k2;

    // Shared multiplier.
    logic signed [VW+FW:0]   r_mpp, mpp_lo;
    logic signed [PW-1:0]    r_mprod, mprod;
    logic signed [PW-FW-1:0] mph;
    t_val                    mul_a, mul_b, len_s;
    t_sat                    m_res;

    // Shared divider.
    logic [DW-1:0]   r_dnum, r_dquo, dnum;
    logic [VW-1:0]   r_drem, r_dden, ua, ub, rem_next;
    logic [VW:0]     rem_sh;
    logic            fire, r_dneg, r_dnneg, r_dnz, r_dzero;
    logic [CNTW-1:0] r_dcnt;
    t_sat            div_n, q_res;
    t_val            div_d, c3_val, post_val;
    logic            post_clamp, cfg_hit, accept;

    assign len_s   = {1'b0, r_len};
    assign cfg_hit = i_cfg_we && (i_cfg_index <= REG_LEN);
    assign busy    = r_busy;
    assign accept  = start && !r_busy;

    // Operand selection per derivation step.
    always_comb begin
        mul_a = len_s;
        mul_b = len_s;
        div_n = '{val: r_n, clamp: 1'b0};
        div_d = len_s;
        d_next = D_IDLE;
        unique case (r_dstate)
            D_T2:  begin mul_a = len_s; mul_b = len_s; d_next = D_T3; end
            D_T3:  begin mul_a = len_s; mul_b = r_t2; d_next = D_N0A; end
            D_N0A: begin mul_a = r_t2; mul_b = r_a0; d_next = D_N0B; end
            D_N0B: begin mul_a = r_v0; mul_b = len_s; d_next = D_K0; end
            D_K0:  begin div_d = r_t3; d_next = D_N1; end
            D_N1:  begin mul_a = r_a0; mul_b = len_s; d_next = D_K1; end
            D_K1:  begin div_d = r_t2; d_next = D_K2; end
            D_K2:  begin div_n = sub_sat(r_a1, r_a0); div_d = len_s; d_next = D_C3; end
            D_C3:  d_next = D_C4;
            D_C4:  begin div_d = len_s; d_next = D_C5; end
            D_C5:  begin div_d = r_t2; d_next = D_IDLE; end
            default: d_next = D_IDLE;
        endcase
    end

    // Multiplier datapath: low partial product, then high part and sum, then round.
    assign mpp_lo = mul_a * $signed({1'b0, mul_b[FW-1:0]});
    assign mph    = mul_a * $signed(mul_b[VW-1:FW]);
    assign mprod  = (PW'(mph) <<< FW) + PW'(r_mpp);
    assign m_res  = mul_round(r_mprod);

    // Divider setup: magnitudes and a rounding half-divisor in the dividend.
    assign ua   = div_n.val[VW-1] ? -div_n.val : div_n.val;
    assign ub   = div_d[VW-1] ? -div_d : div_d;
    assign dnum = {ua, {FW{1'b0}}} + DW'(ub >> 1);

    // One restoring divider step.
    assign rem_sh   = {r_drem, r_dnum[DW-1]};
    assign fire     = rem_sh >= {1'b0, r_dden};
    assign rem_next = fire ? VW'(rem_sh - {1'b0, r_dden}) : rem_sh[VW-1:0];

    // Quotient sign and clamp; a zero divisor gives zero or the extreme of the sign.
    always_comb begin
        q_res = '{val: '0, clamp: 1'b0};
        if (r_dzero) begin
            q_res.clamp = r_dnz;
            q_res.val   = !r_dnz ? '0 : (r_dnneg ? VMIN : VMAX);
        end else if (r_dneg) begin
            q_res.clamp = r_dquo > {{(DW-VW){1'b0}}, VMIN};
            q_res.val   = q_res.clamp ? VMIN : -r_dquo[VW-1:0];
        end else begin
            q_res.clamp = r_dquo > {{(DW-VW){1'b0}}, VMAX};
            q_res.val   = q_res.clamp ? VMAX : r_dquo[VW-1:0];
        end
    end

    // Additions and scalings that follow each multiply or divide.
    always_comb begin
        t_sat s_a, s_b, s_c, s_d, s_e, s_f, s_g, s_h;
        s_a = '0; s_b = '0; s_c = '0; s_d = '0;
        s_e = '0; s_f = '0; s_g = '0; s_h = '0;
        post_val   = r_n;
        post_clamp = 1'b0;
        c3_val     = '0;
        unique case (r_dstate)
            D_T2, D_T3: post_clamp = m_res.clamp;
            D_N0A: begin
                s_a = sub_sat(r_x1, half(m_res.val));
                post_val = s_a.val;
                post_clamp = m_res.clamp | s_a.clamp;
            end
            D_N0B: begin
                s_a = sub_sat(r_n, m_res.val);
                s_b = sub_sat(s_a.val, r_x0);
                post_val = s_b.val;
                post_clamp = m_res.clamp | s_a.clamp | s_b.clamp;
            end
            D_N1: begin
                s_a = sub_sat(r_v1, m_res.val);
                s_b = sub_sat(s_a.val, r_v0);
                post_val = s_b.val;
                post_clamp = m_res.clamp | s_a.clamp | s_b.clamp;
            end
            D_C3: begin
                s_a = scale_sat(8'sd20, r_k0);
                s_b = scale_sat(8'sd8, r_k1);
                s_c = sub_sat(s_a.val, s_b.val);
                s_d = add_sat(s_c.val, r_k2);
                c3_val = half(s_d.val);
                s_e = scale_sat(-8'sd15, r_k0);
                s_f = scale_sat(8'sd7, r_k1);
                s_g = add_sat(s_e.val, s_f.val);
                s_h = sub_sat(s_g.val, r_k2);
                post_val = s_h.val;
                post_clamp = s_a.clamp | s_b.clamp | s_c.clamp | s_d.clamp
                           | s_e.clamp | s_f.clamp | s_g.clamp | s_h.clamp;
            end
            D_C4: begin
                s_a = scale_sat(8'sd6, r_k0);
                s_b = scale_sat(8'sd3, r_k1);
                s_c = sub_sat(s_a.val, s_b.val);
                s_d = add_sat(s_c.val, half(r_k2));
                post_val = s_d.val;
                post_clamp = q_res.clamp | s_a.clamp | s_b.clamp | s_c.clamp | s_d.clamp;
            end
            D_K0, D_K1, D_K2, D_C5: post_clamp = q_res.clamp;
            default: post_clamp = 1'b0;
        endcase
    end

    // Configuration writes and the coefficient derivation sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstate <= D_IDLE;
            r_ph     <= PH_LOAD;
            r_busy   <= 1'b0;
            r_dsat   <= 1'b0;
            r_dclamp <= 1'b0;
            r_x0 <= '0; r_v0 <= '0; r_a0 <= '0;
            r_x1 <= '0; r_v1 <= '0; r_a1 <= '0;
            r_len <= LEN_ONE;
            for (int i = 0; i < NCOEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (cfg_hit) begin
            unique case (i_cfg_index)
                REG_X0:  r_x0 <= i_cfg_data;
                REG_V0:  r_v0 <= i_cfg_data;
                REG_A0:  r_a0 <= i_cfg_data;
                REG_X1:  r_x1 <= i_cfg_data;
                REG_V1:  r_v1 <= i_cfg_data;
                REG_A1:  r_a1 <= i_cfg_data;
                REG_LEN: r_len <= i_cfg_data[LW-1:0];
                default: r_len <= r_len;
            endcase
            r_dstate <= D_T2;
            r_ph     <= PH_LOAD;
            r_busy   <= 1'b1;
            r_dclamp <= 1'b0;
        end else begin
            unique case (r_dstate) inside
                D_T2, D_T3, D_N0A, D_N0B, D_N1: begin
                    unique case (r_ph)
                        PH_LOAD: begin
                            r_mpp <= mpp_lo;
                            r_ph  <= PH_RUN;
                            if (r_dstate == D_T2) begin
                                r_coef[0] <= r_x0;
                                r_coef[1] <= r_v0;
                                r_coef[2] <= half(r_a0);
                            end
                        end
                        PH_RUN: begin
                            r_mprod <= mprod;
                            r_ph    <= PH_DONE;
                        end
                        default: begin
                            r_dclamp <= r_dclamp | post_clamp;
                            if (r_dstate == D_T2) begin
                                r_t2 <= m_res.val;
                            end else if (r_dstate == D_T3) begin
                                r_t3 <= m_res.val;
                            end else begin
                                r_n <= post_val;
                            end
                            r_dstate <= d_next;
                            r_ph     <= PH_LOAD;
                        end
                    endcase
                end
                D_K0, D_K1, D_K2, D_C4, D_C5: begin
                    unique case (r_ph)
                        PH_LOAD: begin
                            r_dclamp <= r_dclamp | div_n.clamp;
                            r_dnz    <= div_n.val != '0;
                            r_dnneg  <= div_n.val[VW-1];
                            r_dneg   <= div_n.val[VW-1] ^ div_d[VW-1];
                            r_dnum   <= dnum;
                            r_dden   <= ub;
                            r_drem   <= '0;
                            r_dquo   <= '0;
                            r_dcnt   <= CNTW'(DW);
                            r_dzero  <= ub == '0;
                            r_ph     <= (ub == '0) ? PH_DONE : PH_RUN;
                        end
                        PH_RUN: begin
                            r_drem <= rem_next;
                            r_dnum <= r_dnum << 1;
                            r_dquo <= {r_dquo[DW-2:0], fire};
                            r_dcnt <= r_dcnt - CNTW'(1);
                            if (r_dcnt == CNTW'(1)) begin
                                r_ph <= PH_DONE;
                            end
                        end
                        default: begin
                            r_dclamp <= r_dclamp | post_clamp;
                            unique case (r_dstate)
                                D_K0: r_k0 <= q_res.val;
                                D_K1: r_k1 <= q_res.val;
                                D_K2: r_k2 <= q_res.val;
                                D_C4: begin
                                    r_coef[4] <= q_res.val;
                                    r_n       <= post_val;
                                end
                                default: begin
                                    r_coef[5] <= q_res.val;
                                    r_dsat    <= r_dclamp | post_clamp;
                                    r_busy    <= 1'b0;
                                end
                            endcase
                            r_dstate <= d_next;
                            r_ph     <= PH_LOAD;
                        end
                    endcase
                end
                D_C3: begin
                    r_coef[3] <= c3_val;
                    r_n       <= post_val;
                    r_dclamp  <= r_dclamp | post_clamp;
                    r_dstate  <= d_next;
                    r_ph      <= PH_LOAD;
                end
                default: r_dstate <= D_IDLE;
            endcase
        end
    end

    // Evaluation pipeline registers.
    logic                    r_in_v;
    t_item                   r_in;
    logic                    r_va [NSTEP];
    logic                    r_vb [NSTEP];
    logic                    r_vc [NSTEP+1];
    t_evs                    r_ea [NSTEP];
    t_evs                    r_eb [NSTEP];
    t_evs                    r_sc [NSTEP+1];
    logic signed [VW+FW:0]   r_pplo [NSTEP];
    logic signed [PW-FW-1:0] r_pphi [NSTEP];
    t_sat                    r_sca [NSTEP];
    t_sat                    r_scb [NSTEP];
    t_sat                    r_mb  [NSTEP];
    logic                    r_out_v;
    t_result                 r_out;
    t_sat                    init_sc;
    t_val                    coef_sel;
    logic                    out_act;

    // Input beat capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= accept;
        end
        if (accept) begin
            r_in <= i_item;
        end
    end

    // Init stage: highest weighted coefficient.
    assign init_sc = scale_sat(WEIGHT[r_in.derivative_order][NCOEF-1], r_coef[NCOEF-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc[0] <= 1'b0;
        end else begin
            r_vc[0] <= r_in_v;
        end
        r_sc[0] <= '{k: r_in.derivative_order, t: r_in.eval_point,
                     acc: init_sc.val, flag: init_sc.clamp};
    end

    // Horner steps, from power four down to power zero.
    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam int J = NSTEP - 1 - s;
        logic signed [PW-1:0] prod;
        t_sat                 mr, ar;
        logic                 act;

        assign prod = (PW'(r_pphi[s]) <<< FW) + PW'(r_pplo[s]);
        assign mr   = mul_round(prod);
        assign ar   = add_sat(r_mb[s].val, r_scb[s].val);
        assign act  = r_eb[s].k <= KW'(J);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va[s]   <= 1'b0;
                r_vb[s]   <= 1'b0;
                r_vc[s+1] <= 1'b0;
            end else begin
                r_va[s]   <= r_vc[s];
                r_vb[s]   <= r_va[s];
                r_vc[s+1] <= r_vb[s];
            end
            // Partial products and weighted coefficient.
            r_pplo[s] <= r_sc[s].acc * $signed({1'b0, r_sc[s].t[FW-1:0]});
            r_pphi[s] <= r_sc[s].acc * $signed(r_sc[s].t[VW-1:FW]);
            r_sca[s]  <= scale_sat(WEIGHT[r_sc[s].k][J], r_coef[J]);
            r_ea[s]   <= r_sc[s];
            // Rounded product.
            r_mb[s]   <= mr;
            r_scb[s]  <= r_sca[s];
            r_eb[s]   <= r_ea[s];
            // Accumulate, or pass through below the requested order.
            r_sc[s+1].k    <= r_eb[s].k;
            r_sc[s+1].t    <= r_eb[s].t;
            r_sc[s+1].acc  <= act ? ar.val : r_eb[s].acc;
            r_sc[s+1].flag <= r_eb[s].flag
                            | (act & (r_mb[s].clamp | r_scb[s].clamp | ar.clamp));
        end
    end

    // Output stage: coefficient pick and zeroing above order five.
    always_comb begin
        coef_sel = '0;
        for (int i = 0; i < NCOEF; i++) begin
            if (r_sc[NSTEP].k == KW'(i)) begin
                coef_sel = r_coef[i];
            end
        end
    end

    assign out_act = r_sc[NSTEP].k <= KW'(NCOEF - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_vc[NSTEP];
        end
        r_out.value       <= out_act ? r_sc[NSTEP].acc : '0;
        r_out.coefficient <= out_act ? coef_sel : '0;
        r_out.saturated   <= out_act & (r_sc[NSTEP].flag | r_dsat);
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

    // A write to a known register starts a derivation.
    `QBPE_ASSERT_NXT(a_cfg_busy, cfg_hit, r_busy, "config write did not raise busy")
    // Every result beat comes from a start beat a fixed latency earlier.
    `QBPE_ASSERT_IMP(a_out_lat, r_out_v, $past(accept, LAT), "result beat without start")
    // The derivation flag only moves at the end of a derivation.
    `QBPE_ASSERT_NXT(a_dsat_hold, !r_busy && !cfg_hit, $stable(r_dsat), "derive flag moved")
    // A clamped derivation marks every non-zero result.
    `QBPE_ASSERT_IMP(a_dsat_out,
        r_out_v && r_dsat && (r_out.value != '0 || r_out.coefficient != '0),
        r_out.saturated, "derive clamp not reported")

endmodule
